// ----- hdl/crcfc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame checker.
`default_nettype none

package crcfc_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int          HDR_BYTES  = 16;
    localparam logic [16:0] LEN_LO_POS = 17'd14;
    localparam logic [16:0] LEN_HI_POS = 17'd15;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_VALID    = 2'd1,
        ST_BAD_CRC  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic [15:0] frame_length;
        logic [16:0] byte_position;
        t_status     status;
    } t_result;

    // MSB-first CRC-16, no reflection, one byte per call
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/crc16_frame_checker_top.sv -----
// Result path: each accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the sink takes results; the CRC byte update sits between the two registers.
// Every accepted byte yields exactly one result item.
// Reset (i_rst_n low, synchronous) empties both stages and clears the frame
// counter, length, running CRC and stored CRC byte; the next byte is byte 0.
`default_nettype none

module crc16_frame_checker_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tuser,   // [0] restart
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [71:0] o_m_tdata    // [1:0] status, [18:2] byte_position,
                                     // [34:19] frame_length, [50:35] computed_crc,
                                     // [66:51] received_crc, [71:67] zero
);

    crcfc_pkg::t_in_item in_item;
    crcfc_pkg::t_in_item core_item;
    crcfc_pkg::t_result  core_result;
    crcfc_pkg::t_result  out_result;
    logic                core_valid;
    logic                out_ready;

    assign in_item.data_byte = i_s_tdata;
    assign in_item.restart   = i_s_tuser;

    crcfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_ready (out_ready),
        .o_item  (core_item)
    );

    crcfc_frame_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (core_valid && out_ready),
        .i_item    (core_item),
        .o_result  (core_result)
    );

    crcfc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {5'd0,
                        out_result.received_crc,
                        out_result.computed_crc,
                        out_result.frame_length,
                        out_result.byte_position,
                        out_result.status};

`ifndef SYNTHESIS
    // a verdict can only come on the second CRC byte, at byte 17 or later
    a_verdict_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_result.status != crcfc_pkg::ST_CONTINUE
        |-> out_result.byte_position >= 17'd17)
        else $error("verdict before end of minimal frame");

    a_rx_only_at_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_result.status == crcfc_pkg::ST_CONTINUE
        |-> out_result.received_crc == 16'd0)
        else $error("received crc reported outside verdict");

    a_valid_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_result.status == crcfc_pkg::ST_VALID
        |-> out_result.received_crc == out_result.computed_crc)
        else $error("valid verdict with crc mismatch");
`endif

endmodule

`default_nettype wire

// ----- hdl/crcfc_in_stage.sv -----
// Input register stage: holds one received item until the core takes it.
`default_nettype none

module crcfc_in_stage (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire crcfc_pkg::t_in_item i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output crcfc_pkg::t_in_item      o_item
);

    logic                r_valid;
    crcfc_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/crcfc_frame_core.sv -----
// Frame tracking state and per-byte CRC/verdict logic.
`default_nettype none

module crcfc_frame_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_advance,
    input  wire crcfc_pkg::t_in_item i_item,
    output crcfc_pkg::t_result       o_result
);

    logic [16:0] r_byte_count;
    logic [15:0] r_payload_length;
    logic [15:0] r_running_crc;
    logic [7:0]  r_crc_low_byte;

    logic [16:0] n_byte_count;
    logic [15:0] n_payload_length;
    logic [15:0] n_running_crc;
    logic [7:0]  n_crc_low_byte;

    logic [16:0] pos;
    logic [15:0] len_base;
    logic [15:0] crc_base;
    logic [16:0] crc_end;
    logic [15:0] crc_new;
    logic [15:0] rx_crc;
    crcfc_pkg::t_status status;

    always_comb begin
        pos      = i_item.restart ? 17'd0 : r_byte_count;
        // byte 0 starts a fresh frame
        len_base = (pos == 17'd0) ? 16'd0 : r_payload_length;
        crc_base = (pos == 17'd0) ? 16'd0 : r_running_crc;
        crc_end  = {1'b0, len_base} + 17'(crcfc_pkg::HDR_BYTES);
        crc_new  = crcfc_pkg::crc_add_byte(crc_base, i_item.data_byte);

        n_byte_count     = pos + 17'd1;
        n_payload_length = len_base;
        n_running_crc    = crc_base;
        n_crc_low_byte   = r_crc_low_byte;
        rx_crc           = 16'd0;
        status           = crcfc_pkg::ST_CONTINUE;

        if (pos < 17'(crcfc_pkg::HDR_BYTES)) begin
            n_running_crc = crc_new;
            if (pos == crcfc_pkg::LEN_LO_POS) begin
                n_payload_length = {len_base[15:8], i_item.data_byte};
            end else if (pos == crcfc_pkg::LEN_HI_POS) begin
                n_payload_length = {i_item.data_byte, len_base[7:0]};
            end
        end else if (pos < crc_end) begin
            n_running_crc = crc_new;
        end else if (pos == crc_end) begin
            n_crc_low_byte = i_item.data_byte;
        end else begin
            rx_crc       = {i_item.data_byte, r_crc_low_byte};
            status       = (rx_crc == crc_base) ? crcfc_pkg::ST_VALID
                                                : crcfc_pkg::ST_BAD_CRC;
            n_byte_count = 17'd0;
        end
    end

    always_comb begin
        o_result.status        = status;
        o_result.byte_position = pos;
        o_result.frame_length  = n_payload_length;
        o_result.computed_crc  = n_running_crc;
        o_result.received_crc  = rx_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count     <= 17'd0;
            r_payload_length <= 16'd0;
            r_running_crc    <= 16'd0;
            r_crc_low_byte   <= 8'd0;
        end else if (i_advance) begin
            r_byte_count     <= n_byte_count;
            r_payload_length <= n_payload_length;
            r_running_crc    <= n_running_crc;
            r_crc_low_byte   <= n_crc_low_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/crcfc_out_stage.sv -----
// Result register stage: holds one result until the sink takes it.
`default_nettype none

module crcfc_out_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire crcfc_pkg::t_result i_result,
    output logic                    o_valid,
    input  wire                     i_ready,
    output crcfc_pkg::t_result      o_result
);

    logic               r_valid;
    crcfc_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
